### hdl/pitt_pkg.sv
`default_nettype none
package pitt_pkg;

	localparam int CoordBits = 16;
	localparam int TolW      = 16;
	localparam int DiffW     = CoordBits + 1;
	localparam int CofW      = 2 * DiffW + 1;
	localparam int DetW      = DiffW + CofW + 2;
	localparam int MulAW     = (DiffW > TolW + 1) ? DiffW : TolW + 1;
	localparam int MulBW     = DetW + 1;
	localparam int ProdW     = MulAW + MulBW;
	localparam int ThrW      = TolW + DetW;
	localparam int FracBits  = 32;
	localparam int CmpW      = DetW + FracBits;
	localparam int StepW     = 4;
	localparam int LastStep  = 10;
	localparam int DetIdxW   = 3;
	localparam int LastDet   = 4;
	localparam logic [TolW-1:0] TolReset = 16'd4295;

	localparam logic CmdLoad = 1'b0;
	localparam logic CmdTest = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SET_C1,
		OP_SUB_C1,
		OP_SET_C2,
		OP_SUB_C2,
		OP_SET_C3,
		OP_SUB_C3,
		OP_SET_DET,
		OP_SUB_DET,
		OP_ADD_DET,
		OP_SET_THR
	} op_t;

endpackage
`default_nettype wire

### hdl/point_in_tetrahedron_test_unit.sv
// Point-in-tetrahedron test.
// Input channel (in_valid / in_stall) carries one request per item. A request
// with command load writes coord_x/y/z into the corner named by vertex_index
// and gives no result. A request with command test checks the point against
// the four stored corners and gives one result on the output channel
// (out_valid / out_stall): inside_res, and degenerate when the stored
// tetrahedron has zero volume.
// A test runs five 3x3 determinants through one shared multiplier, only the
// first when the volume is zero. in_stall is high from the request until the
// result goes to the output register, so a new test is not taken before the
// last one is through.
// cfg_ready is always high; the user writes the tolerance register over
// cfg_valid / cfg_tolerance only while the block is idle (not enforced).
// The result waits in an output register while out_stall is high; new load
// requests are still taken then, and a finished test waits for the register.
// Reset clears the control state and sets the tolerance to 4295; corners are
// undefined until loaded.
`default_nettype none
module point_in_tetrahedron_test_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   command,
	input  wire  [1:0]                            vertex_index,
	input  wire  signed [pitt_pkg::CoordBits-1:0] coord_x,
	input  wire  signed [pitt_pkg::CoordBits-1:0] coord_y,
	input  wire  signed [pitt_pkg::CoordBits-1:0] coord_z,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  inside_res,
	output logic                                  degenerate,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [pitt_pkg::TolW-1:0]             cfg_tolerance
);

	localparam int CB = pitt_pkg::CoordBits;

	pitt_pkg::state_t state_q, state_d;

	logic signed [CB-1:0] vx_q [4];
	logic signed [CB-1:0] vy_q [4];
	logic signed [CB-1:0] vz_q [4];
	logic signed [CB-1:0] px_q, py_q, pz_q;
	logic [pitt_pkg::TolW-1:0] tol_q;

	logic [pitt_pkg::StepW-1:0]   step_q;
	logic [pitt_pkg::DetIdxW-1:0] k_q;

	logic signed [pitt_pkg::CofW-1:0] c1_q, c2_q, c3_q;
	logic signed [pitt_pkg::DetW-1:0] det_q;
	logic [pitt_pkg::ThrW-1:0]        thr_q;
	logic                             dneg_q;
	logic                             ok_q;
	logic                             deg_q;
	logic signed [pitt_pkg::ProdW-1:0] prod_s1;
	pitt_pkg::op_t                    op_s1;

	logic out_valid_q, inside_q, degen_q;

	logic signed [CB-1:0] sx [4];
	logic signed [CB-1:0] sy [4];
	logic signed [CB-1:0] sz [4];
	logic signed [pitt_pkg::DiffW-1:0] bx, by, bz, cx, cy, cz, dx, dy, dz;
	logic signed [pitt_pkg::MulAW-1:0] mul_a;
	logic signed [pitt_pkg::MulBW-1:0] mul_b;
	pitt_pkg::op_t op;
	logic [pitt_pkg::DetW-1:0] det_abs;
	logic coord_fail;
	logic in_acc, out_acc, last_step, det_zero, finish;

	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign last_step = (step_q == pitt_pkg::StepW'(pitt_pkg::LastStep));
	assign det_zero  = (det_q == '0);
	assign det_abs   = det_q[pitt_pkg::DetW-1] ? pitt_pkg::DetW'(-det_q)
	                                           : pitt_pkg::DetW'(det_q);
	assign finish    = (state_q == pitt_pkg::ST_RUN) && last_step &&
	                   ((k_q == '0 && det_zero) ||
	                    k_q == pitt_pkg::DetIdxW'(pitt_pkg::LastDet));

	// A coordinate fails when it is negative and |N| * 2^32 exceeds tol * |D|.
	assign coord_fail = !det_zero && (det_q[pitt_pkg::DetW-1] != dneg_q) &&
	                    ({det_abs, pitt_pkg::FracBits'(0)} >
	                     pitt_pkg::CmpW'(thr_q));

	// Corners of the current determinant: the query point replaces corner k-1.
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (k_q == pitt_pkg::DetIdxW'(j + 1)) begin
				sx[j] = px_q;
				sy[j] = py_q;
				sz[j] = pz_q;
			end else begin
				sx[j] = vx_q[j];
				sy[j] = vy_q[j];
				sz[j] = vz_q[j];
			end
		end
	end

	assign bx = pitt_pkg::DiffW'(sx[1]) - pitt_pkg::DiffW'(sx[0]);
	assign by = pitt_pkg::DiffW'(sy[1]) - pitt_pkg::DiffW'(sy[0]);
	assign bz = pitt_pkg::DiffW'(sz[1]) - pitt_pkg::DiffW'(sz[0]);
	assign cx = pitt_pkg::DiffW'(sx[2]) - pitt_pkg::DiffW'(sx[0]);
	assign cy = pitt_pkg::DiffW'(sy[2]) - pitt_pkg::DiffW'(sy[0]);
	assign cz = pitt_pkg::DiffW'(sz[2]) - pitt_pkg::DiffW'(sz[0]);
	assign dx = pitt_pkg::DiffW'(sx[3]) - pitt_pkg::DiffW'(sx[0]);
	assign dy = pitt_pkg::DiffW'(sy[3]) - pitt_pkg::DiffW'(sy[0]);
	assign dz = pitt_pkg::DiffW'(sz[3]) - pitt_pkg::DiffW'(sz[0]);

	// Operand selection for the shared multiplier, at most one product per step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		op    = pitt_pkg::OP_NONE;
		if (state_q == pitt_pkg::ST_RUN) begin
			case (step_q)
				4'd0: begin
					mul_a = pitt_pkg::MulAW'(cy); mul_b = pitt_pkg::MulBW'(dz);
					op = pitt_pkg::OP_SET_C1;
				end
				4'd1: begin
					mul_a = pitt_pkg::MulAW'(cz); mul_b = pitt_pkg::MulBW'(dy);
					op = pitt_pkg::OP_SUB_C1;
				end
				4'd2: begin
					mul_a = pitt_pkg::MulAW'(cx); mul_b = pitt_pkg::MulBW'(dz);
					op = pitt_pkg::OP_SET_C2;
				end
				4'd3: begin
					mul_a = pitt_pkg::MulAW'(cz); mul_b = pitt_pkg::MulBW'(dx);
					op = pitt_pkg::OP_SUB_C2;
				end
				4'd4: begin
					mul_a = pitt_pkg::MulAW'(cx); mul_b = pitt_pkg::MulBW'(dy);
					op = pitt_pkg::OP_SET_C3;
				end
				4'd5: begin
					mul_a = pitt_pkg::MulAW'(cy); mul_b = pitt_pkg::MulBW'(dx);
					op = pitt_pkg::OP_SUB_C3;
				end
				4'd6: begin
					mul_a = pitt_pkg::MulAW'(bx); mul_b = pitt_pkg::MulBW'(c1_q);
					op = pitt_pkg::OP_SET_DET;
				end
				4'd7: begin
					mul_a = pitt_pkg::MulAW'(by); mul_b = pitt_pkg::MulBW'(c2_q);
					op = pitt_pkg::OP_SUB_DET;
				end
				4'd8: begin
					mul_a = pitt_pkg::MulAW'(bz); mul_b = pitt_pkg::MulBW'(c3_q);
					op = pitt_pkg::OP_ADD_DET;
				end
				4'd10: begin
					if (k_q == '0) begin
						mul_a = signed'({1'b0, tol_q});
						mul_b = signed'({1'b0, det_abs});
						op = pitt_pkg::OP_SET_THR;
					end
				end
				default: begin
					op = pitt_pkg::OP_NONE;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pitt_pkg::ST_IDLE: begin
				if (in_acc && command == pitt_pkg::CmdTest)
					state_d = pitt_pkg::ST_RUN;
			end
			pitt_pkg::ST_RUN: begin
				if (finish)
					state_d = pitt_pkg::ST_DONE;
			end
			pitt_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = pitt_pkg::ST_IDLE;
			end
			default: state_d = pitt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != pitt_pkg::ST_IDLE);
		cfg_ready  = 1'b1;
		out_valid  = out_valid_q;
		inside_res = inside_q;
		degenerate = degen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pitt_pkg::ST_IDLE;
			tol_q       <= pitt_pkg::TolReset;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			k_q         <= '0;
			op_s1       <= pitt_pkg::OP_NONE;
		end else begin
			state_q <= state_d;
			op_s1   <= op;
			if (cfg_valid && cfg_ready)
				tol_q <= cfg_tolerance;
			if (state_q == pitt_pkg::ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;
			if (state_q == pitt_pkg::ST_RUN && !finish) begin
				if (last_step) begin
					step_q <= '0;
					k_q    <= k_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end else begin
				step_q <= '0;
				k_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (in_acc) begin
			if (command == pitt_pkg::CmdLoad) begin
				vx_q[vertex_index] <= coord_x;
				vy_q[vertex_index] <= coord_y;
				vz_q[vertex_index] <= coord_z;
			end else begin
				px_q <= coord_x;
				py_q <= coord_y;
				pz_q <= coord_z;
				ok_q <= 1'b1;
			end
		end
		case (op_s1)
			pitt_pkg::OP_SET_C1:  c1_q  <= prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SUB_C1:  c1_q  <= c1_q - prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SET_C2:  c2_q  <= prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SUB_C2:  c2_q  <= c2_q - prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SET_C3:  c3_q  <= prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SUB_C3:  c3_q  <= c3_q - prod_s1[pitt_pkg::CofW-1:0];
			pitt_pkg::OP_SET_DET: det_q <= prod_s1[pitt_pkg::DetW-1:0];
			pitt_pkg::OP_SUB_DET: det_q <= det_q - prod_s1[pitt_pkg::DetW-1:0];
			pitt_pkg::OP_ADD_DET: det_q <= det_q + prod_s1[pitt_pkg::DetW-1:0];
			pitt_pkg::OP_SET_THR: thr_q <= prod_s1[pitt_pkg::ThrW-1:0];
			default: ;
		endcase
		if (state_q == pitt_pkg::ST_RUN && last_step) begin
			if (k_q == '0) begin
				dneg_q <= det_q[pitt_pkg::DetW-1];
				deg_q  <= det_zero;
			end else if (coord_fail) begin
				ok_q <= 1'b0;
			end
		end
		if (state_q == pitt_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
			inside_q <= ok_q && !deg_q;
			degen_q  <= deg_q;
		end
	end

endmodule
`default_nettype wire
